FILE: src/modular_exponentiation_macros.svh
// ----------------------------------------------------------------------------
// modular_exponentiation_macros.svh
// Assertion macros shared by the modular exponentiation block.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// Same-cycle implication, checked outside reset
`define MODEXP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define MODEXP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/modexp_pkg.sv
// ----------------------------------------------------------------------------
// modexp_pkg
// Types and constants shared by the modular exponentiation modules.
// ----------------------------------------------------------------------------
`default_nettype none

package modexp_pkg;

    localparam int WORD_BITS_DEFAULT = 32;
    localparam int FIELD_BITS        = 32;

    localparam logic [FIELD_BITS-1:0] RESET_MODULUS = FIELD_BITS'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_DBL,
        ST_ADD,
        ST_DONE
    } seq_state_t;

    // top level to sequencer
    typedef struct packed {
        logic start;
        logic ack;
    } seq_ctrl_t;

    // sequencer to top level
    typedef struct packed {
        logic idle;
        logic done;
    } seq_status_t;

endpackage

`default_nettype wire

FILE: src/modexp_addmod.sv
// ----------------------------------------------------------------------------
// modexp_addmod
// Shared add, compare and subtract unit: (x + y + cin) mod m for x, y < m.
// ----------------------------------------------------------------------------
`default_nettype none

module modexp_addmod #(
    parameter int WORD_BITS = modexp_pkg::WORD_BITS_DEFAULT
) (
    input  wire logic [WORD_BITS-1:0] x,
    input  wire logic [WORD_BITS-1:0] y,
    input  wire logic                 cin,
    input  wire logic [WORD_BITS:0]   m,
    output logic      [WORD_BITS-1:0] sum
);

    logic [WORD_BITS:0] raw;
    logic [WORD_BITS:0] diff;

    // raw stays below 2m, so one subtract brings it into range
    assign raw  = {1'b0, x} + {1'b0, y} + {{WORD_BITS{1'b0}}, cin};
    assign diff = raw - m;
    assign sum  = (raw >= m) ? diff[WORD_BITS-1:0] : raw[WORD_BITS-1:0];

endmodule

`default_nettype wire

FILE: src/modexp_seq.sv
// ----------------------------------------------------------------------------
// modexp_seq
// Sequencer for square-and-multiply; every step goes through one add-mod unit.
// ----------------------------------------------------------------------------
`default_nettype none

module modexp_seq #(
    parameter int WORD_BITS = modexp_pkg::WORD_BITS_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire modexp_pkg::seq_ctrl_t  ctrl,
    output modexp_pkg::seq_status_t     status,
    input  wire logic [WORD_BITS-1:0]   base_w,
    input  wire logic [WORD_BITS-1:0]   expo_w,
    input  wire logic [WORD_BITS-1:0]   mod_w,
    output logic      [WORD_BITS-1:0]   result
);

    localparam int CNT_BITS = $clog2(WORD_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

    modexp_pkg::seq_state_t state_reg, state_next;

    logic [WORD_BITS:0]   m_reg, m_next;
    logic [WORD_BITS-1:0] base_sh_reg, base_sh_next;
    logic [WORD_BITS-1:0] red_reg, red_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS-1:0] mul_a_reg, mul_a_next;
    logic [WORD_BITS-1:0] mul_b_reg, mul_b_next;
    logic [WORD_BITS-1:0] r_reg, r_next;
    logic [WORD_BITS-1:0] e_sh_reg, e_sh_next;
    logic [CNT_BITS-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [CNT_BITS-1:0]  exp_cnt_reg, exp_cnt_next;
    logic                 sq_reg, sq_next;

    logic [WORD_BITS-1:0] unit_x;
    logic [WORD_BITS-1:0] unit_y;
    logic                 unit_cin;
    logic [WORD_BITS-1:0] unit_sum;

    modexp_addmod #(
        .WORD_BITS (WORD_BITS)
    ) u_addmod (
        .x   (unit_x),
        .y   (unit_y),
        .cin (unit_cin),
        .m   (m_reg),
        .sum (unit_sum)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= modexp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg       <= m_next;
        base_sh_reg <= base_sh_next;
        red_reg     <= red_next;
        acc_reg     <= acc_next;
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        r_reg       <= r_next;
        e_sh_reg    <= e_sh_next;
        bit_cnt_reg <= bit_cnt_next;
        exp_cnt_reg <= exp_cnt_next;
        sq_reg      <= sq_next;
    end

    always_comb
    begin
        logic                 start_mult;
        logic                 step_end;
        logic [WORD_BITS-1:0] mult_a_in;
        logic [WORD_BITS-1:0] mult_b_in;
        logic                 mult_sq_in;

        state_next   = state_reg;
        m_next       = m_reg;
        base_sh_next = base_sh_reg;
        red_next     = red_reg;
        acc_next     = acc_reg;
        mul_a_next   = mul_a_reg;
        mul_b_next   = mul_b_reg;
        r_next       = r_reg;
        e_sh_next    = e_sh_reg;
        bit_cnt_next = bit_cnt_reg;
        exp_cnt_next = exp_cnt_reg;
        sq_next      = sq_reg;

        start_mult = 1'b0;
        step_end   = 1'b0;
        mult_a_in  = r_reg;
        mult_b_in  = r_reg;
        mult_sq_in = 1'b1;

        unit_x   = r_reg;
        unit_y   = r_reg;
        unit_cin = 1'b0;

        case (state_reg)
            modexp_pkg::ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    // a zero modulus means wrap at the word width
                    m_next = (mod_w == '0) ? {1'b1, {WORD_BITS{1'b0}}} : {1'b0, mod_w};
                    if (expo_w == '0)
                    begin
                        acc_next   = WORD_BITS'(1);
                        state_next = modexp_pkg::ST_DONE;
                    end
                    else
                    begin
                        base_sh_next = base_w;
                        red_next     = '0;
                        e_sh_next    = expo_w;
                        bit_cnt_next = CNT_LAST;
                        exp_cnt_next = CNT_LAST;
                        state_next   = modexp_pkg::ST_REDUCE;
                    end
                end
            end

            modexp_pkg::ST_REDUCE:
            begin
                // shift the base in MSB first, keep the remainder below m
                unit_x       = red_reg;
                unit_y       = red_reg;
                unit_cin     = base_sh_reg[WORD_BITS-1];
                red_next     = unit_sum;
                base_sh_next = {base_sh_reg[WORD_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - CNT_BITS'(1);
                if (bit_cnt_reg == '0)
                begin
                    mult_a_in  = (m_reg == (WORD_BITS+1)'(1)) ? '0 : WORD_BITS'(1);
                    mult_b_in  = mult_a_in;
                    mult_sq_in = 1'b1;
                    start_mult = 1'b1;
                end
            end

            modexp_pkg::ST_DBL:
            begin
                r_next = unit_sum;
                if (mul_b_reg[WORD_BITS-1])
                begin
                    state_next = modexp_pkg::ST_ADD;
                end
                else
                begin
                    step_end = 1'b1;
                end
            end

            modexp_pkg::ST_ADD:
            begin
                unit_y   = mul_a_reg;
                r_next   = unit_sum;
                step_end = 1'b1;
            end

            modexp_pkg::ST_DONE:
            begin
                if (ctrl.ack)
                begin
                    state_next = modexp_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = modexp_pkg::ST_IDLE;
            end
        endcase

        // advance to the next multiplier bit, or finish this product
        if (step_end)
        begin
            mul_b_next = {mul_b_reg[WORD_BITS-2:0], 1'b0};
            if (bit_cnt_reg != '0)
            begin
                bit_cnt_next = bit_cnt_reg - CNT_BITS'(1);
                state_next   = modexp_pkg::ST_DBL;
            end
            else if (sq_reg && e_sh_reg[WORD_BITS-1])
            begin
                mult_a_in  = unit_sum;
                mult_b_in  = red_reg;
                mult_sq_in = 1'b0;
                start_mult = 1'b1;
            end
            else if (exp_cnt_reg == '0)
            begin
                acc_next   = unit_sum;
                state_next = modexp_pkg::ST_DONE;
            end
            else
            begin
                exp_cnt_next = exp_cnt_reg - CNT_BITS'(1);
                e_sh_next    = {e_sh_reg[WORD_BITS-2:0], 1'b0};
                mult_a_in    = unit_sum;
                mult_b_in    = unit_sum;
                mult_sq_in   = 1'b1;
                start_mult   = 1'b1;
            end
        end

        if (start_mult)
        begin
            mul_a_next   = mult_a_in;
            mul_b_next   = mult_b_in;
            sq_next      = mult_sq_in;
            r_next       = '0;
            bit_cnt_next = CNT_LAST;
            state_next   = modexp_pkg::ST_DBL;
        end
    end

    assign status.idle = (state_reg == modexp_pkg::ST_IDLE);
    assign status.done = (state_reg == modexp_pkg::ST_DONE);
    assign result      = acc_reg;

endmodule

`default_nettype wire

FILE: src/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes base_value to the power exponent, modulo the configured modulus.
// ----------------------------------------------------------------------------
// One request at a time: the block takes a request, raises the base by
// square-and-multiply over all WORD_BITS exponent bits and offers one result.
// Every step runs through a single add-and-reduce unit, one step a cycle:
// first the base is reduced bit by bit, then per exponent bit comes a squaring
// plus, for a set bit, a multiply by the reduced base; each product takes a
// doubling per multiplier bit and an add for each set one. A zero exponent goes
// straight to the result 1. The next request is taken as soon as the result
// sits in the output register. A modulus of zero wraps at the word width.
// ----------------------------------------------------------------------------
`default_nettype none

`include "modular_exponentiation_macros.svh"

module modular_exponentiation #(
    parameter int WORD_BITS = modexp_pkg::WORD_BITS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [modexp_pkg::FIELD_BITS-1:0] cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [modexp_pkg::FIELD_BITS-1:0] base_value,
    input  wire logic [modexp_pkg::FIELD_BITS-1:0] exponent,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [modexp_pkg::FIELD_BITS-1:0] power_result
);

    logic [modexp_pkg::FIELD_BITS-1:0] modulus_reg;
    logic                              out_valid_reg, out_valid_next;
    logic [modexp_pkg::FIELD_BITS-1:0] result_reg, result_next;

    modexp_pkg::seq_ctrl_t   ctrl;
    modexp_pkg::seq_status_t status;
    logic [WORD_BITS-1:0]    core_result;
    logic                    in_fire;
    logic                    load_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= modexp_pkg::RESET_MODULUS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                modulus_reg <= cfg_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign in_ready = status.idle;
    assign in_fire  = in_valid && in_ready;
    // take the result once the output register is free or draining
    assign load_out = status.done && (!out_valid_reg || out_ready);

    assign ctrl.start = in_fire;
    assign ctrl.ack   = load_out;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            result_next    = modexp_pkg::FIELD_BITS'(core_result);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    modexp_seq #(
        .WORD_BITS (WORD_BITS)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .status (status),
        .base_w (WORD_BITS'(base_value)),
        .expo_w (WORD_BITS'(exponent)),
        .mod_w  (WORD_BITS'(modulus_reg)),
        .result (core_result)
    );

    assign out_valid    = out_valid_reg;
    assign power_result = result_reg;

    `MODEXP_ASSERT_NEXT(a_busy_after_request, in_fire, !in_ready,
        "block still ready after taking a request")
    `MODEXP_ASSERT_NEXT(a_done_fills_output, status.done && !out_valid_reg, out_valid,
        "finished result not moved to the output register")
    `MODEXP_ASSERT_IMP(a_output_from_core, $rose(out_valid), $past(status.done),
        "output became valid without a finished result")

endmodule

`default_nettype wire

FILE: tb/sv/modexp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_checker
// Watches the request and result channels of the modular exponentiation
// block, predicts each power from the sampled modulus and compares results
// in order, counting every mismatch for the testbench top.
// ----------------------------------------------------------------------------
module modexp_checker
    import modexp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [FIELD_BITS-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [FIELD_BITS-1:0] base_value,
    input  logic [FIELD_BITS-1:0] exponent,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [FIELD_BITS-1:0] power_result,
    output int                    mismatches,
    output int                    outstanding
);

    typedef logic [FIELD_BITS-1:0] word_t;

    word_t modulus_q;
    word_t expected_powers[$];
    int    fail_cnt;

    // exact product reduction; a zero modulus wraps at the word width
    function automatic logic [63:0] mul_reduce(logic [63:0] a, logic [63:0] b, word_t m);
        logic [63:0] prod;
        prod = a * b;
        if (m == '0)
            return prod & {{(64-FIELD_BITS){1'b0}}, {FIELD_BITS{1'b1}}};
        return prod % 64'(m);
    endfunction

    function automatic word_t raise_mod(word_t b, word_t e, word_t m);
        logic [63:0] acc;
        logic [63:0] base_r;
        if (e == '0)
            return word_t'(1);
        base_r = (m == '0) ? 64'(b) : 64'(b) % 64'(m);
        acc    = (m == word_t'(1)) ? 64'd0 : 64'd1;
        for (int i = FIELD_BITS - 1; i >= 0; i--)
        begin
            acc = mul_reduce(acc, acc, m);
            if (e[i])
                acc = mul_reduce(acc, base_r, m);
        end
        return word_t'(acc);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        word_t want;
        if (!rst_n)
        begin
            expected_powers.delete();
            modulus_q = RESET_MODULUS;
            fail_cnt  = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_write)
                modulus_q = cfg_data;
            if (in_valid && in_ready)
                expected_powers.push_back(raise_mod(base_value, exponent, modulus_q));
            if (out_valid && out_ready)
            begin
                if (expected_powers.size() == 0)
                begin
                    $error("power_result: unexpected result %0h with no request pending",
                           power_result);
                    fail_cnt++;
                end
                else
                begin
                    want = expected_powers.pop_front();
                    if (power_result !== want)
                    begin
                        $error("power_result: expected %0h, actual %0h", want, power_result);
                        fail_cnt++;
                    end
                end
            end
            mismatches  <= fail_cnt;
            outstanding <= expected_powers.size();
        end
    end

endmodule

FILE: tb/sv/tb_modular_exponentiation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modular_exponentiation
// Drives directed and random power requests into the modular exponentiation
// block under several modulus settings, with random idling on both channels,
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation;

    import modexp_pkg::*;

    typedef logic [FIELD_BITS-1:0] word_t;

    localparam int CLK_PERIOD   = 8;
    localparam int STALL_LIMIT  = 60000;
    localparam int LONG_HOLD    = 12000;
    localparam int HOLD_AFTER   = 45;
    localparam int DRAIN_CYCLES = 64;
    localparam int NUM_PHASES   = 7;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  cfg_write;
    word_t cfg_data;
    logic  in_valid;
    logic  in_ready;
    word_t base_value;
    word_t exponent;
    logic  out_valid;
    logic  out_ready;
    word_t power_result;

    int mismatches;
    int outstanding;
    int sent = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    modular_exponentiation i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .base_value   (base_value),
        .exponent     (exponent),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .power_result (power_result)
    );

    modexp_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .base_value   (base_value),
        .exponent     (exponent),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .power_result (power_result),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        if (r < 97)
            return $urandom_range(5, 30);
        return $urandom_range(100, 400);
    endfunction

    function automatic word_t pick_base(word_t m);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return m;
            3: return m - word_t'(1);
            4, 5: return word_t'($urandom_range(0, 20));
            default: return word_t'($urandom);
        endcase
    endfunction

    function automatic word_t pick_exponent();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return word_t'(1);
            2: return '1;
            3: return word_t'($urandom_range(2, 40));
            default: return word_t'($urandom);
        endcase
    endfunction

    task automatic offer_request(word_t b, word_t e);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        base_value <= b;
        exponent   <= e;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        // the checker count is registered and lags behind the last request
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic load_modulus(word_t m);
        wait_all_results();
        cfg_write <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // receiver: random stalls, one long hold while requests keep coming
    initial
    begin
        int  stall;
        bit  held;
        held = 1'b0;
        out_ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 300)) @(posedge clk);
            stall = pick_gap();
            if (!held && sent >= HOLD_AFTER)
            begin
                stall = LONG_HOLD;
                held  = 1'b1;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("modular_exponentiation: mismatch");
        $finish;
    end

    initial
    begin
        word_t m;
        int    count;
        rst_n      <= 1'b0;
        cfg_write  <= 1'b0;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        base_value <= '0;
        exponent   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset modulus of one: zero exponent gives 1, anything else 0
        offer_request(32'd5, 32'd0);
        offer_request(32'd0, 32'd0);
        offer_request(32'hFFFF_FFFF, 32'd7);
        offer_request(32'd1, 32'hFFFF_FFFF);

        load_modulus(32'hFFFF_FFFF);
        offer_request(32'd0, 32'hFFFF_FFFF);
        offer_request(32'hFFFF_FFFF, 32'd1);
        offer_request(32'hFFFF_FFFF, 32'd0);
        offer_request(32'd2, 32'd31);
        offer_request(32'hFFFF_FFFE, 32'd2);
        offer_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        offer_request(32'h89AB_CDEF, 32'h1234_5678);

        load_modulus(32'd23);
        offer_request(32'd5, 32'd6);
        offer_request(32'd100, 32'd22);
        offer_request(32'd46, 32'd3);
        offer_request(32'd0, 32'd0);
        offer_request(32'd22, 32'hFFFF_FFFF);

        load_modulus(32'd4294967291);
        offer_request(32'd2, 32'd4294967290);
        offer_request(32'd4294967291, 32'd5);
        offer_request(32'd3, 32'h7FFF_FFFD);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                1: m = 32'hFFFF_FFFF;
                2: m = word_t'($urandom_range(2, 64));
                3: m = word_t'(1);
                4: m = 32'd4294967291;
                6: m = word_t'(2);
                default:
                begin
                    do
                        m = word_t'($urandom);
                    while (m == '0);
                end
            endcase
            load_modulus(m);
            // first phase is longer so the long receiver hold lands inside it
            count = (p == 0) ? 50 : 37;
            repeat (count)
                offer_request(pick_base(m), pick_exponent());
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("modular_exponentiation: match");
        else
            $display("modular_exponentiation: mismatch");
        $finish;
    end

endmodule
